>>> sv/flsa_pkg.sv
// Shared constants, types and helpers for the free-list slot allocator.
`timescale 1ns / 1ps

package flsa_pkg;

	// Field and register widths
	localparam int OP_W     = 1;
	localparam int SLOT_W   = 6;
	localparam int COUNT_W  = 7;
	localparam int BYTES_W  = 17;
	localparam int OFFSET_W = 22;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;

	// Default pool depth
	localparam int DEF_NUM_SLOTS = 64;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES = 1'd1;

	// Register reset values
	localparam logic [COUNT_W-1:0] RESET_SLOT_COUNT   = 7'd64;
	localparam logic [BYTES_W-1:0] RESET_BUFFER_BYTES = 17'd2048;

	// Largest usable buffer size
	localparam logic [BYTES_W-1:0] MAX_BYTES = 17'd65536;

	// Request codes
	localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD_SLOT  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;     // latch the request beat, read the head link
		logic commit;     // apply the request and load the result
		logic init_step;  // write one link entry of the rebuild pass
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic rebuild;    // slot_count written this cycle
		logic init_last;  // rebuild pass at its last entry
	} stat_t;

	// Map a slot_count value onto the number of slots in use
	function automatic logic [COUNT_W-1:0] active_of(input logic [COUNT_W-1:0] cnt,
			input int num);
		logic [COUNT_W-1:0] res;
		if (cnt == '0) begin
			res = COUNT_W'(1);
		end else if (int'(cnt) > num) begin
			res = COUNT_W'(num);
		end else begin
			res = cnt;
		end
		return res;
	endfunction

endpackage

>>> sv/free_list_slot_allocator.sv
// Top level of the LIFO free-list slot allocator.
// Each request (allocate or free) passes two controller states: on accept in the idle state
// the link-table entry of the head slot is read, and in the execute state, once the output
// register has room, the request is committed and its result beat is loaded there; in_stall
// stays high until the commit, so no new request is taken before the last is committed. A
// finished result waits in the output register while the next request is accepted. After
// reset and after every slot_count write the link table is rebuilt over all NUM_SLOTS
// entries with in_stall high; write configuration only while no request is in flight.
`timescale 1ns / 1ps

module free_list_slot_allocator #(
	parameter int NUM_SLOTS = flsa_pkg::DEF_NUM_SLOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [flsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [flsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [flsa_pkg::OP_W-1:0]         op,
	input  logic [flsa_pkg::SLOT_W-1:0]       slot_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [flsa_pkg::STATUS_W-1:0]     status,
	output logic [flsa_pkg::SLOT_W-1:0]       slot_out,
	output logic [flsa_pkg::OFFSET_W-1:0]     byte_offset,
	output logic [flsa_pkg::COUNT_W-1:0]      free_slots
);

	flsa_pkg::cmd_t  cmd;
	flsa_pkg::stat_t stat;

	flsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	flsa_dpath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.slot_in     (slot_in),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.slot_out    (slot_out),
		.byte_offset (byte_offset),
		.free_slots  (free_slots)
	);

endmodule

>>> sv/flsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module flsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/flsa_ctrl.sv
// Controller state machine: rebuild pass, request accept and commit sequencing.
`timescale 1ns / 1ps

module flsa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  flsa_pkg::stat_t stat,
	output flsa_pkg::cmd_t  cmd
);

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       room;

	// Result register can take a new beat
	assign room = !out_valid_q || !out_stall;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_INIT: begin
				cmd.init_step = !stat.rebuild;
				if (stat.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.commit = room;
				if (room) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
		// A slot_count write restarts the rebuild pass
		if (stat.rebuild) begin
			state_d = ST_INIT;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Result beat valid: set on commit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/flsa_dpath.sv
// Datapath: free-list head, link table, free bits, counters and result register.
`timescale 1ns / 1ps

module flsa_dpath #(
	parameter int NUM_SLOTS = flsa_pkg::DEF_NUM_SLOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [flsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [flsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [flsa_pkg::OP_W-1:0]         op,
	input  logic [flsa_pkg::SLOT_W-1:0]       slot_in,
	input  flsa_pkg::cmd_t                    cmd,
	output flsa_pkg::stat_t                   stat,
	output logic [flsa_pkg::STATUS_W-1:0]     status,
	output logic [flsa_pkg::SLOT_W-1:0]       slot_out,
	output logic [flsa_pkg::OFFSET_W-1:0]     byte_offset,
	output logic [flsa_pkg::COUNT_W-1:0]      free_slots
);

	localparam int SW  = flsa_pkg::SLOT_W;
	localparam int CW  = flsa_pkg::COUNT_W;
	localparam int BW  = flsa_pkg::BYTES_W;
	localparam int OW  = flsa_pkg::OFFSET_W;
	localparam int IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int LW  = $clog2(NUM_SLOTS + 1);
	localparam int PW  = IW + BW;
	// Only slots reachable by slot_in can be freed, so only those need a free bit
	localparam int FREE_N = (NUM_SLOTS < (2 ** SW)) ? NUM_SLOTS : (2 ** SW);
	localparam logic [LW-1:0] END_MARK = LW'(NUM_SLOTS);
	localparam logic [CW-1:0] RST_ACTIVE =
		flsa_pkg::active_of(flsa_pkg::RESET_SLOT_COUNT, NUM_SLOTS);

	// Architectural state
	logic [IW-1:0]         head_q;
	logic                  empty_q;
	logic [CW-1:0]         free_cnt_q;
	logic [CW-1:0]         active_q;
	logic [BW-1:0]         bytes_q;
	logic [FREE_N-1:0]     slot_free_q;
	logic [IW-1:0]         init_cnt_q;

	// Latched request beat
	logic [flsa_pkg::OP_W-1:0] op_q;
	logic [SW-1:0]             slot_q;

	// Link table ports
	logic          link_we;
	logic [IW-1:0] link_waddr;
	logic [LW-1:0] link_wdata;
	logic [LW-1:0] link_rdata;
	logic [LW-1:0] init_link;

	// Commit logic
	logic [CW-1:0]  new_active;
	logic [BW-1:0]  bytes_eff;
	logic [PW-1:0]  prod;
	logic           is_alloc;
	logic           alloc_ok;
	logic           free_ok;
	logic           slot_is_free;
	logic           nxt_end;
	logic [IW-1:0]  head_d;
	logic           empty_d;
	logic [CW-1:0]  cnt_d;
	logic [flsa_pkg::STATUS_W-1:0] res_status;

	// Slot-count write decode
	assign stat.rebuild   = cfg_wr_en && (cfg_index == flsa_pkg::REG_SLOT_COUNT);
	assign stat.init_last = (init_cnt_q == IW'(NUM_SLOTS - 1));
	assign new_active     = flsa_pkg::active_of(cfg_data[CW-1:0], NUM_SLOTS);

	// Rebuild entry: i links to i+1, the last active slot to the end mark
	assign init_link = ((32'(init_cnt_q) + 32'd1) < 32'(active_q))
		? LW'(32'(init_cnt_q) + 32'd1) : END_MARK;

	// Clamp buffer size and form the offset of the head slot
	assign bytes_eff = (bytes_q > flsa_pkg::MAX_BYTES) ? flsa_pkg::MAX_BYTES : bytes_q;
	assign prod      = PW'(head_q) * PW'(bytes_eff);

	// Look up the free bit of the requested slot
	always_comb begin
		slot_is_free = 1'b0;
		for (int i = 0; i < FREE_N; i++) begin
			if (slot_q == SW'(i)) begin
				slot_is_free = slot_free_q[i];
			end
		end
	end

	// Decide the request outcome and next list state
	always_comb begin
		is_alloc = (op_q == flsa_pkg::OP_ALLOC);
		alloc_ok = !empty_q;
		free_ok  = (32'(slot_q) < 32'(active_q)) && (32'(slot_q) < 32'(NUM_SLOTS))
			&& !slot_is_free;
		nxt_end  = (32'(link_rdata) >= 32'(NUM_SLOTS));
		head_d   = head_q;
		empty_d  = empty_q;
		cnt_d    = free_cnt_q;
		if (is_alloc) begin
			res_status = alloc_ok ? flsa_pkg::STAT_OK : flsa_pkg::STAT_EXHAUSTED;
			if (alloc_ok) begin
				if (free_cnt_q != '0) begin
					cnt_d = free_cnt_q - CW'(1);
				end
				if (nxt_end) begin
					empty_d = 1'b1;
					head_d  = '0;
				end else begin
					head_d = link_rdata[IW-1:0];
				end
			end
		end else begin
			res_status = free_ok ? flsa_pkg::STAT_OK : flsa_pkg::STAT_BAD_SLOT;
			if (free_ok) begin
				head_d  = IW'(slot_q);
				empty_d = 1'b0;
				cnt_d   = free_cnt_q + CW'(1);
			end
		end
	end

	// Link table writes: rebuild pass, or push of a freed slot
	always_comb begin
		link_we    = cmd.init_step || (cmd.commit && !is_alloc && free_ok);
		link_waddr = cmd.init_step ? init_cnt_q : IW'(slot_q);
		link_wdata = cmd.init_step ? init_link : (empty_q ? END_MARK : LW'(head_q));
	end

	flsa_ram #(
		.WIDTH (LW),
		.DEPTH (NUM_SLOTS)
	) u_links (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (cmd.accept),
		.raddr (head_q),
		.rdata (link_rdata)
	);

	// List state, free bits, rebuild counter and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			empty_q    <= 1'b0;
			free_cnt_q <= RST_ACTIVE;
			active_q   <= RST_ACTIVE;
			bytes_q    <= flsa_pkg::RESET_BUFFER_BYTES;
			init_cnt_q <= '0;
			for (int i = 0; i < FREE_N; i++) begin
				slot_free_q[i] <= (i < int'(RST_ACTIVE));
			end
		end else begin
			if (cfg_wr_en && (cfg_index == flsa_pkg::REG_BUFFER_BYTES)) begin
				bytes_q <= cfg_data[BW-1:0];
			end
			if (stat.rebuild) begin
				head_q     <= '0;
				empty_q    <= 1'b0;
				free_cnt_q <= new_active;
				active_q   <= new_active;
				init_cnt_q <= '0;
				for (int i = 0; i < FREE_N; i++) begin
					slot_free_q[i] <= (i < int'(new_active));
				end
			end else begin
				if (cmd.init_step) begin
					init_cnt_q <= init_cnt_q + IW'(1);
				end
				if (cmd.commit) begin
					head_q     <= head_d;
					empty_q    <= empty_d;
					free_cnt_q <= cnt_d;
					for (int i = 0; i < FREE_N; i++) begin
						if (is_alloc && alloc_ok && (32'(head_q) == 32'(i))) begin
							slot_free_q[i] <= 1'b0;
						end
						if (!is_alloc && free_ok && (slot_q == SW'(i))) begin
							slot_free_q[i] <= 1'b1;
						end
					end
				end
			end
		end
	end

	// Hold the accepted request beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op;
			slot_q <= slot_in;
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status      <= res_status;
			slot_out    <= (is_alloc && alloc_ok) ? SW'(head_q) : '0;
			byte_offset <= (is_alloc && alloc_ok) ? OW'(prod) : '0;
			free_slots  <= cnt_d;
		end
	end

	// The counter never claims more free slots than are in use
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= active_q)
		else $error("free count above active slot count");

	// The empty flag and the counter agree
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q == (free_cnt_q == '0))
		else $error("empty flag and free count disagree");

	// A non-empty list heads with an active slot
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> (32'(head_q) < 32'(active_q)))
		else $error("head slot outside active range");

	// A successful allocate removes exactly one free slot
	a_alloc_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_alloc && alloc_ok && !stat.rebuild)
		|=> (free_cnt_q == $past(free_cnt_q) - CW'(1)))
		else $error("allocate did not consume one slot");

endmodule

>>> test/tb_free_list_slot_allocator.sv
// Self-checking testbench for the LIFO free-list slot allocator.
`timescale 1ns / 1ps

module tb_free_list_slot_allocator;

	localparam int POOL_DEPTH = flsa_pkg::DEF_NUM_SLOTS;
	localparam logic [flsa_pkg::COUNT_W-1:0] LINK_END = flsa_pkg::COUNT_W'(POOL_DEPTH);

	typedef struct packed {
		logic [flsa_pkg::STATUS_W-1:0] status;
		logic [flsa_pkg::SLOT_W-1:0]   slot;
		logic [flsa_pkg::OFFSET_W-1:0] offset;
		logic [flsa_pkg::COUNT_W-1:0]  free;
	} slot_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wr_en = 1'b0;
	logic [flsa_pkg::CFG_IDX_W-1:0]  cfg_index = flsa_pkg::REG_SLOT_COUNT;
	logic [flsa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [flsa_pkg::OP_W-1:0]       op = flsa_pkg::OP_ALLOC;
	logic [flsa_pkg::SLOT_W-1:0]     slot_in = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [flsa_pkg::STATUS_W-1:0]   status;
	logic [flsa_pkg::SLOT_W-1:0]     slot_out;
	logic [flsa_pkg::OFFSET_W-1:0]   byte_offset;
	logic [flsa_pkg::COUNT_W-1:0]    free_slots;

	// Shadow of the allocator state
	logic [flsa_pkg::COUNT_W-1:0] shadow_slot_count;
	logic [flsa_pkg::BYTES_W-1:0] shadow_buffer_bytes;
	logic [flsa_pkg::SLOT_W-1:0]  pool_head;
	logic                         pool_empty;
	logic [flsa_pkg::COUNT_W-1:0] pool_link [POOL_DEPTH];
	logic [flsa_pkg::COUNT_W-1:0] pool_free_cnt;
	logic                         slot_is_free [POOL_DEPTH];

	slot_result_t pending_results [$];
	int           error_count = 0;
	int           result_count = 0;
	logic         idle_enable = 1'b1;

	free_list_slot_allocator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.slot_in     (slot_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.slot_out    (slot_out),
		.byte_offset (byte_offset),
		.free_slots  (free_slots)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		out_stall <= idle_enable && ($urandom_range(99) < 21);
	end

	// Number of slots in use for the current slot_count
	function automatic int slots_in_use();
		if (shadow_slot_count == '0)
			return 1;
		if (int'(shadow_slot_count) > POOL_DEPTH)
			return POOL_DEPTH;
		return int'(shadow_slot_count);
	endfunction

	// Rebuild the shadow list as 0 .. N-1, all free
	function automatic void rebuild_pool();
		int n;
		n = slots_in_use();
		for (int i = 0; i < POOL_DEPTH; i++) begin
			pool_link[i] = (i + 1 < n) ? flsa_pkg::COUNT_W'(i + 1) : LINK_END;
			slot_is_free[i] = (i < n);
		end
		pool_head = '0;
		pool_empty = 1'b0;
		pool_free_cnt = flsa_pkg::COUNT_W'(n);
	endfunction

	// Apply one request to the shadow state and return its result
	function automatic slot_result_t apply_request(input logic [flsa_pkg::OP_W-1:0] req_op,
			input logic [flsa_pkg::SLOT_W-1:0] req_slot);
		slot_result_t res;
		logic [flsa_pkg::COUNT_W-1:0] nxt;
		logic [flsa_pkg::BYTES_W-1:0] bytes;
		res = '0;
		if (req_op == flsa_pkg::OP_ALLOC) begin
			if (pool_empty) begin
				res.status = flsa_pkg::STAT_EXHAUSTED;
			end else begin
				bytes = (shadow_buffer_bytes > flsa_pkg::MAX_BYTES)
					? flsa_pkg::MAX_BYTES : shadow_buffer_bytes;
				nxt = pool_link[pool_head];
				res.status = flsa_pkg::STAT_OK;
				res.slot = pool_head;
				res.offset = flsa_pkg::OFFSET_W'(int'(pool_head) * int'(bytes));
				slot_is_free[pool_head] = 1'b0;
				if (pool_free_cnt != '0)
					pool_free_cnt = pool_free_cnt - flsa_pkg::COUNT_W'(1);
				if (int'(nxt) >= POOL_DEPTH) begin
					pool_empty = 1'b1;
					pool_head = '0;
				end else begin
					pool_head = nxt[flsa_pkg::SLOT_W-1:0];
				end
			end
		end else begin
			if (int'(req_slot) >= slots_in_use() || slot_is_free[req_slot]) begin
				res.status = flsa_pkg::STAT_BAD_SLOT;
			end else begin
				pool_link[req_slot] = pool_empty ? LINK_END
					: flsa_pkg::COUNT_W'(pool_head);
				pool_head = req_slot;
				pool_empty = 1'b0;
				slot_is_free[req_slot] = 1'b1;
				pool_free_cnt = pool_free_cnt + flsa_pkg::COUNT_W'(1);
			end
		end
		res.free = pool_free_cnt;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s got %0d expected %0d", result_count, what,
			got, want);
		error_count++;
	endtask

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin : check_results
		slot_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat, status", int'(status), -1);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", int'(status), int'(want.status));
				if (slot_out !== want.slot)
					report_mismatch("slot_out", int'(slot_out), int'(want.slot));
				if (byte_offset !== want.offset)
					report_mismatch("byte_offset", int'(byte_offset), int'(want.offset));
				if (free_slots !== want.free)
					report_mismatch("free_slots", int'(free_slots), int'(want.free));
			end
			result_count++;
		end
	end

	// Send one request beat; called and returning at a falling edge
	task automatic send_request(input logic [flsa_pkg::OP_W-1:0] req_op,
			input logic [flsa_pkg::SLOT_W-1:0] req_slot);
		while (idle_enable && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= req_op;
		slot_in <= req_slot;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(apply_request(req_op, req_slot));
		@(negedge clk);
	endtask

	// Hold the sender until every expected result has come back
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	// Drain and let the block settle before a register write
	task automatic settle_idle();
		hold_until_drained();
		repeat (4) @(negedge clk);
	endtask

	// Write one register; block is idle
	task automatic write_reg(input logic [flsa_pkg::CFG_IDX_W-1:0] idx,
			input logic [flsa_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == flsa_pkg::REG_SLOT_COUNT) begin
			shadow_slot_count = data[flsa_pkg::COUNT_W-1:0];
			rebuild_pool();
		end else begin
			shadow_buffer_bytes = data[flsa_pkg::BYTES_W-1:0];
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Pick a mostly well-formed request: allocate, or free a slot now in use
	task automatic send_random_request(input int alloc_pct);
		int in_use [$];
		if ($urandom_range(99) < 30) begin
			send_request(flsa_pkg::OP_W'($urandom_range(1)),
				flsa_pkg::SLOT_W'($urandom_range(63)));
		end else if ($urandom_range(99) < alloc_pct) begin
			send_request(flsa_pkg::OP_ALLOC, '0);
		end else begin
			for (int i = 0; i < slots_in_use(); i++)
				if (!slot_is_free[i])
					in_use.push_back(i);
			if (in_use.size() == 0)
				send_request(flsa_pkg::OP_ALLOC, flsa_pkg::SLOT_W'($urandom_range(63)));
			else
				send_request(flsa_pkg::OP_FREE,
					flsa_pkg::SLOT_W'(in_use[$urandom_range(in_use.size() - 1)]));
		end
	endtask

	// Reset values: first grants, double free, free of a slot never granted
	task automatic test_reset_config();
		send_request(flsa_pkg::OP_ALLOC, '0);
		send_request(flsa_pkg::OP_ALLOC, 6'd63);
		send_request(flsa_pkg::OP_ALLOC, '0);
		send_request(flsa_pkg::OP_FREE, 6'd1);
		send_request(flsa_pkg::OP_FREE, 6'd1);
		send_request(flsa_pkg::OP_FREE, 6'd63);
		send_request(flsa_pkg::OP_ALLOC, '0);
		send_request(flsa_pkg::OP_FREE, 6'd2);
		send_request(flsa_pkg::OP_FREE, 6'd1);
		send_request(flsa_pkg::OP_FREE, 6'd0);
	endtask

	// Register extremes: one slot, zero and clamped sizes, exhausted pool
	task automatic test_config_limits();
		settle_idle();
		write_reg(flsa_pkg::REG_SLOT_COUNT, 17'd1);
		write_reg(flsa_pkg::REG_BUFFER_BYTES, 17'd65536);
		send_request(flsa_pkg::OP_ALLOC, '0);
		send_request(flsa_pkg::OP_ALLOC, '0);
		send_request(flsa_pkg::OP_FREE, 6'd1);
		send_request(flsa_pkg::OP_FREE, 6'd0);
		send_request(flsa_pkg::OP_FREE, 6'd0);
		send_request(flsa_pkg::OP_ALLOC, '0);
		settle_idle();
		write_reg(flsa_pkg::REG_BUFFER_BYTES, 17'd0);
		write_reg(flsa_pkg::REG_SLOT_COUNT, 17'd0);
		send_request(flsa_pkg::OP_ALLOC, '0);
		send_request(flsa_pkg::OP_ALLOC, '0);
		settle_idle();
		write_reg(flsa_pkg::REG_SLOT_COUNT, 17'd2);
		write_reg(flsa_pkg::REG_BUFFER_BYTES, 17'h1FFFF);
		send_request(flsa_pkg::OP_ALLOC, '0);
		send_request(flsa_pkg::OP_ALLOC, '0);
		send_request(flsa_pkg::OP_ALLOC, '0);
		send_request(flsa_pkg::OP_FREE, 6'd1);
		send_request(flsa_pkg::OP_FREE, 6'd0);
		send_request(flsa_pkg::OP_ALLOC, '0);
		send_request(flsa_pkg::OP_ALLOC, '0);
	endtask

	// Back-to-back traffic with no idling on either side
	task automatic test_full_rate();
		settle_idle();
		write_reg(flsa_pkg::REG_SLOT_COUNT, 17'd8);
		write_reg(flsa_pkg::REG_BUFFER_BYTES, 17'd1500);
		idle_enable = 1'b0;
		for (int i = 0; i < 150; i++)
			send_random_request(55);
		hold_until_drained();
		idle_enable = 1'b1;
	endtask

	// Random traffic over a range of pool sizes and buffer sizes
	task automatic test_random_phases();
		int counts [8] = '{64, 1, 0, 127, 8, 3, 100, 0};
		int sizes [8] = '{131071, 1, 0, 65536, 2048, 0, 0, 0};
		int pcts [8] = '{95, 50, 50, 90, 60, 45, 70, 0};
		int cnt;
		int bytes;
		int pct;
		for (int p = 0; p < 8; p++) begin
			cnt = (p == 7) ? $urandom_range(1, 64) : counts[p];
			bytes = (p >= 5) ? $urandom_range(131071) : sizes[p];
			pct = (p == 7) ? $urandom_range(35, 75) : pcts[p];
			settle_idle();
			write_reg(flsa_pkg::REG_BUFFER_BYTES, flsa_pkg::CFG_DATA_W'(bytes));
			// upper data bits are outside the slot_count register
			write_reg(flsa_pkg::REG_SLOT_COUNT,
				(flsa_pkg::CFG_DATA_W'($urandom) & ~flsa_pkg::CFG_DATA_W'(7'h7F))
				| flsa_pkg::CFG_DATA_W'(cnt));
			for (int i = 0; i < 95; i++) begin
				if (i == 50 || $urandom_range(99) < 2)
					hold_until_drained();
				send_random_request(pct);
			end
		end
	endtask

	initial begin
		shadow_slot_count = flsa_pkg::RESET_SLOT_COUNT;
		shadow_buffer_bytes = flsa_pkg::RESET_BUFFER_BYTES;
		rebuild_pool();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_config();
		test_config_limits();
		test_full_rate();
		test_random_phases();

		hold_until_drained();
		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("** free_list_slot_allocator: PASSED **");
		else
			$display("** free_list_slot_allocator: FAILED **");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("** free_list_slot_allocator: FAILED **");
		$finish;
	end

endmodule
